// ----- hw/rtl/palette_fade_engine_assert.svh -----
// ----------------------------------------------------------------------------
// Palette fade engine assertion macros
// Concurrent assertion shorthands used by the fade sequencer, pfe_fade_ctrl.
// ----------------------------------------------------------------------------
`ifndef PALETTE_FADE_ENGINE_ASSERT_SVH
`define PALETTE_FADE_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define PFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("palette fade engine: assertion failed");

// Next-cycle implication.
`define PFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("palette fade engine: assertion failed");

`else

`define PFE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PFE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, codes and constants shared by the palette fade engine modules.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int NUM_COLORS = 16;
  localparam int IDX_W      = $clog2(NUM_COLORS);
  localparam int CH_W       = 4;
  localparam int LVL_W      = 5;
  localparam int WAIT_W     = 8;
  localparam int MODE_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CH_W-1:0]         chan_t;
  typedef logic signed [LVL_W-1:0] level_t;

  localparam idx_t   LAST_IDX    = IDX_W'(NUM_COLORS - 1);
  localparam level_t LEVEL_BLACK = -5'sd15;
  localparam level_t LEVEL_ZERO  = 5'sd0;
  localparam level_t LEVEL_WHITE = 5'sd15;

  // Input actions.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Fade modes.
  localparam logic [MODE_W-1:0] MODE_IN_BLACK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OUT_BLACK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OUT_WHITE = 2'd2;

  // Register indexes.
  localparam logic REG_FADE_MODE  = 1'b0;
  localparam logic REG_FRAME_WAIT = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] entry_index;
    logic [3:0] red_in;
    logic [3:0] green_in;
    logic [3:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [3:0] color_index;
    logic [3:0] red_out;
    logic [3:0] green_out;
    logic [3:0] blue_out;
    logic       last_of_level;
    logic       fade_done;
  } out_item_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } color_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    color_t data;
  } ram_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } ram_rd_t;

  // What the sequencer tells the output stage about the entry on the RAM port.
  typedef struct packed {
    logic   ld;
    idx_t   idx;
    logic   last;
    logic   done;
    level_t level;
  } run_info_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } fsm_state_t;

endpackage

// ----- hw/rtl/palette_fade_engine.sv -----
// ----------------------------------------------------------------------------
// palette_fade_engine
// Palette fade engine top level: configuration registers, palette store,
// fade sequencer, color adjustment and the result register.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                     Payload
//   in_       input      in_valid / in_ready           pfe_pkg::in_item_t
//   out_      output     out_valid / out_ready         pfe_pkg::out_item_t
//   APB       config     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A load, a start, an ignored action and a tick that only counts down
// leave in_ready high. A tick that opens a contrast level starts a run
// through the palette store: while out_ready stays high, one entry per
// cycle is read from the store's single read port, adjusted and placed
// in the result register. The first result of a run passes through the
// store's read register and then the result register. While a run is
// in progress in_ready is low; a stall on out_ready holds the run in
// place, since the store is read only when the result register frees
// up. Reset is synchronous; palette entries read as black until written,
// tracked by per-entry valid bits, so no clearing pass is needed.
//
module palette_fade_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pfe_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pfe_pkg::out_item_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pfe_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pfe_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pfe_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  // Configuration registers. Registers sit at byte addresses 0 and 4, so
  // address bit 2 selects between them.
  logic [pfe_pkg::MODE_W-1:0] fade_mode_r, fade_mode_nxt;
  logic [pfe_pkg::WAIT_W-1:0] frame_wait_r, frame_wait_nxt;
  logic                       cfg_write;
  logic                       cfg_sel;

  // Result register.
  logic                       out_valid_r, out_valid_nxt;
  pfe_pkg::out_item_t         out_data_r, out_data_nxt;
  logic                       out_free;

  pfe_pkg::ram_wr_t           ram_wr;
  pfe_pkg::ram_rd_t           ram_rd;
  pfe_pkg::run_info_t         run_info;
  pfe_pkg::color_t            raw_color;
  pfe_pkg::color_t            adj_color;

  assign pready    = 1'b1;
  assign cfg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    fade_mode_nxt  = fade_mode_r;
    frame_wait_nxt = frame_wait_r;
    if (cfg_write) begin
      case (cfg_sel)
        pfe_pkg::REG_FADE_MODE:  fade_mode_nxt  = pwdata[pfe_pkg::MODE_W-1:0];
        pfe_pkg::REG_FRAME_WAIT: frame_wait_nxt = pwdata[pfe_pkg::WAIT_W-1:0];
        default:                 fade_mode_nxt  = fade_mode_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      pfe_pkg::REG_FADE_MODE:  prdata = pfe_pkg::CFG_DATA_W'(fade_mode_r);
      pfe_pkg::REG_FRAME_WAIT: prdata = pfe_pkg::CFG_DATA_W'(frame_wait_r);
      default:                 prdata = '0;
    endcase
  end

  // The sequencer may load the result register whenever it is empty or its
  // current transaction completes in this cycle.
  assign out_free = !out_valid_r || out_ready;

  pfe_fade_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_mode (fade_mode_r),
    .cfg_wait (frame_wait_r),
    .out_free (out_free),
    .ram_wr   (ram_wr),
    .ram_rd   (ram_rd),
    .run_info (run_info)
  );

  // Loads never overlap a run because in_ready is low during one, so a read
  // and a write never target the store in the same cycle.
  pfe_palette_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (ram_wr),
    .rd    (ram_rd),
    .rdata (raw_color)
  );

  pfe_color_adjust u_adjust (
    .raw   (raw_color),
    .level (run_info.level),
    .adj   (adj_color)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (run_info.ld) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.color_index   = 4'(run_info.idx);
      out_data_nxt.red_out       = adj_color.red;
      out_data_nxt.green_out     = adj_color.green;
      out_data_nxt.blue_out      = adj_color.blue;
      out_data_nxt.last_of_level = run_info.last;
      out_data_nxt.fade_done     = run_info.done;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_mode_r  <= pfe_pkg::MODE_IN_BLACK;
      frame_wait_r <= pfe_pkg::WAIT_W'(3);
      out_valid_r  <= 1'b0;
    end else begin
      fade_mode_r  <= fade_mode_nxt;
      frame_wait_r <= frame_wait_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/pfe_palette_ram.sv -----
// ----------------------------------------------------------------------------
// pfe_palette_ram
// Palette store: one write port, one registered read port, per-entry valid
// bits so that entries not yet written read as black.
// ----------------------------------------------------------------------------
module pfe_palette_ram (
  input  logic             clk,
  input  logic             rst_n,
  input  pfe_pkg::ram_wr_t wr,
  input  pfe_pkg::ram_rd_t rd,
  output pfe_pkg::color_t  rdata
);

  pfe_pkg::color_t                 mem_r [pfe_pkg::NUM_COLORS];
  logic [pfe_pkg::NUM_COLORS-1:0]  valid_r;
  pfe_pkg::color_t                 rd_data_r;
  logic                            rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_hit_r <= valid_r[rd.addr];
      end
    end
  end

  assign rdata = rd_hit_r ? rd_data_r : '0;

endmodule

// ----- hw/rtl/pfe_color_adjust.sv -----
// ----------------------------------------------------------------------------
// pfe_color_adjust
// Applies one contrast level to the three channels of a palette entry.
// ----------------------------------------------------------------------------
module pfe_color_adjust (
  input  pfe_pkg::color_t raw,
  input  pfe_pkg::level_t level,
  output pfe_pkg::color_t adj
);

  // A positive level adds and saturates; a negative level scales by
  // (15 + level) / 15, where the divide by 15 is ((p + 1) * 17) >> 8,
  // exact for every product up to 225.
  function automatic pfe_pkg::chan_t adjust_chan(input pfe_pkg::chan_t c,
                                                 input pfe_pkg::level_t lvl);
    logic [4:0]  sum;
    logic [4:0]  lvl_plus;
    logic [7:0]  prod;
    logic [8:0]  prod_p1;
    logic [12:0] scaled;
    pfe_pkg::chan_t res;
    sum      = {1'b0, c} + {1'b0, lvl[3:0]};
    lvl_plus = lvl + 5'sd15;
    prod     = c * lvl_plus[3:0];
    prod_p1  = {1'b0, prod} + 9'd1;
    scaled   = {prod_p1, 4'b0000} + {4'b0000, prod_p1};
    if (lvl > pfe_pkg::LEVEL_ZERO) begin
      res = sum[4] ? 4'hF : sum[3:0];
    end else if (lvl < pfe_pkg::LEVEL_ZERO) begin
      res = scaled[11:8];
    end else begin
      res = c;
    end
    return res;
  endfunction

  always_comb begin
    adj.red   = adjust_chan(raw.red, level);
    adj.green = adjust_chan(raw.green, level);
    adj.blue  = adjust_chan(raw.blue, level);
  end

endmodule

// ----- hw/rtl/pfe_fade_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfe_fade_ctrl
// Fade sequencer: decodes input transactions, keeps the fade state and walks
// the store per contrast level, one entry per cycle while out_free is high.
// ----------------------------------------------------------------------------
`include "palette_fade_engine_assert.svh"

module pfe_fade_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pfe_pkg::in_item_t                  in_data,
  input  logic [pfe_pkg::MODE_W-1:0]         cfg_mode,
  input  logic [pfe_pkg::WAIT_W-1:0]         cfg_wait,
  input  logic                               out_free,
  output pfe_pkg::ram_wr_t                   ram_wr,
  output pfe_pkg::ram_rd_t                   ram_rd,
  output pfe_pkg::run_info_t                 run_info
);

  pfe_pkg::fsm_state_t         state_r, state_nxt;
  pfe_pkg::level_t             contrast_level_r, contrast_level_nxt;
  logic [pfe_pkg::WAIT_W-1:0]  tick_countdown_r, tick_countdown_nxt;
  logic                        fade_active_r, fade_active_nxt;
  logic [pfe_pkg::MODE_W-1:0]  fade_dir_r, fade_dir_nxt;
  pfe_pkg::level_t             run_level_r, run_level_nxt;
  logic                        run_done_r, run_done_nxt;
  pfe_pkg::idx_t               rd_idx_r, rd_idx_nxt;

  logic                        accept;
  logic                        fire;
  logic                        at_last;
  logic                        at_final;
  logic                        run_end;
  logic [pfe_pkg::WAIT_W-1:0]  wait_ticks;
  pfe_pkg::level_t             final_level;

  // Input is taken only between runs.
  assign in_ready   = (state_r == pfe_pkg::ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign at_last    = (rd_idx_r == pfe_pkg::LAST_IDX);
  assign run_end    = (state_r == pfe_pkg::ST_RUN) && out_free && at_last;
  assign wait_ticks = (cfg_wait == '0) ? pfe_pkg::WAIT_W'(1) : cfg_wait;

  always_comb begin
    case (fade_dir_r)
      pfe_pkg::MODE_IN_BLACK:  final_level = pfe_pkg::LEVEL_ZERO;
      pfe_pkg::MODE_OUT_BLACK: final_level = pfe_pkg::LEVEL_BLACK;
      default:                 final_level = pfe_pkg::LEVEL_WHITE;
    endcase
  end

  assign at_final = (contrast_level_r == final_level);

  // A tick opens a run when the countdown for this level has run out.
  assign fire = accept && (in_data.action == pfe_pkg::ACT_TICK) && fade_active_r &&
                (tick_countdown_r <= pfe_pkg::WAIT_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfe_pkg::ST_IDLE: begin
        if (fire) begin
          state_nxt = pfe_pkg::ST_RUN;
        end
      end
      pfe_pkg::ST_RUN: begin
        if (run_end) begin
          state_nxt = pfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pfe_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ram_rd.en    = 1'b0;
    ram_rd.addr  = '0;
    run_info.ld  = 1'b0;
    case (state_r)
      pfe_pkg::ST_IDLE: begin
        ram_rd.en = fire;
      end
      pfe_pkg::ST_RUN: begin
        run_info.ld = out_free;
        ram_rd.en   = out_free && !at_last;
        ram_rd.addr = rd_idx_r + pfe_pkg::IDX_W'(1);
      end
      default: begin
        ram_rd.en = 1'b0;
      end
    endcase
    ram_wr.en   = accept && (in_data.action == pfe_pkg::ACT_LOAD) &&
                  (int'(in_data.entry_index) < pfe_pkg::NUM_COLORS);
    ram_wr.addr = pfe_pkg::IDX_W'(in_data.entry_index);
    ram_wr.data = {in_data.red_in, in_data.green_in, in_data.blue_in};
    run_info.idx   = rd_idx_r;
    run_info.last  = at_last;
    run_info.done  = run_done_r;
    run_info.level = run_level_r;
  end

  // Fade state.
  always_comb begin
    contrast_level_nxt = contrast_level_r;
    tick_countdown_nxt = tick_countdown_r;
    fade_active_nxt    = fade_active_r;
    fade_dir_nxt       = fade_dir_r;
    run_level_nxt      = run_level_r;
    run_done_nxt       = run_done_r;
    rd_idx_nxt         = ram_rd.en ? ram_rd.addr : rd_idx_r;
    if (accept) begin
      case (in_data.action)
        pfe_pkg::ACT_START: begin
          if (cfg_mode <= pfe_pkg::MODE_OUT_WHITE) begin
            fade_dir_nxt       = cfg_mode;
            contrast_level_nxt = (cfg_mode == pfe_pkg::MODE_IN_BLACK) ?
                                 pfe_pkg::LEVEL_BLACK : pfe_pkg::LEVEL_ZERO;
            tick_countdown_nxt = wait_ticks;
            fade_active_nxt    = 1'b1;
          end
        end
        pfe_pkg::ACT_TICK: begin
          if (fire) begin
            run_level_nxt = contrast_level_r;
            run_done_nxt  = at_final;
            if (at_final) begin
              fade_active_nxt    = 1'b0;
              tick_countdown_nxt = '0;
            end else begin
              contrast_level_nxt = (fade_dir_r == pfe_pkg::MODE_OUT_BLACK) ?
                                   contrast_level_r - 5'sd1 : contrast_level_r + 5'sd1;
              tick_countdown_nxt = wait_ticks;
            end
          end else if (fade_active_r) begin
            tick_countdown_nxt = tick_countdown_r - pfe_pkg::WAIT_W'(1);
          end
        end
        default: begin
          fade_active_nxt = fade_active_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= pfe_pkg::ST_IDLE;
      contrast_level_r <= pfe_pkg::LEVEL_ZERO;
      tick_countdown_r <= '0;
      fade_active_r    <= 1'b0;
      fade_dir_r       <= pfe_pkg::MODE_IN_BLACK;
      run_level_r      <= pfe_pkg::LEVEL_ZERO;
      run_done_r       <= 1'b0;
      rd_idx_r         <= '0;
    end else begin
      state_r          <= state_nxt;
      contrast_level_r <= contrast_level_nxt;
      tick_countdown_r <= tick_countdown_nxt;
      fade_active_r    <= fade_active_nxt;
      fade_dir_r       <= fade_dir_nxt;
      run_level_r      <= run_level_nxt;
      run_done_r       <= run_done_nxt;
      rd_idx_r         <= rd_idx_nxt;
    end
  end

  `PFE_ASSERT_NXT(a_run_ends_idle, clk, rst_n, run_end, state_r == pfe_pkg::ST_IDLE)
  `PFE_ASSERT_IMP(a_final_run_inactive, clk, rst_n, !in_ready && run_done_r, !fade_active_r)
  `PFE_ASSERT_IMP(a_cnt_tracks_active, clk, rst_n, 1'b1, fade_active_r == (tick_countdown_r != '0))
  `PFE_ASSERT_IMP(a_level_low, clk, rst_n, fade_active_r, contrast_level_r >= pfe_pkg::LEVEL_BLACK)
  `PFE_ASSERT_IMP(a_level_high, clk, rst_n, fade_active_r, contrast_level_r <= pfe_pkg::LEVEL_WHITE)

endmodule
